### rtl/lbp_pkg.sv
// Shared types and constants for the 3x3 local binary pattern core.
`timescale 1ns / 1ps

package lbp_pkg;

   localparam int PIXEL_W     = 8;
   localparam int IMG_W_W     = 11;
   localparam int IMG_H_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;
   localparam logic [IMG_H_W-1:0] MIN_HEIGHT         = 16'd3;

   // per-pixel position flags, carried with the request down the pipe
   typedef struct packed {
      logic emit;
      logic row_end;
      logic frame_end;
   } lbp_flags_type;

endpackage

### rtl/lbp_3x3_stream_operator_core.sv
// Top level of the streaming 3x3 local binary pattern operator.
`timescale 1ns / 1ps

// Takes one 8-bit pixel per cycle in raster order and returns one LBP code for
// each pixel whose window centre has all eight neighbours, (width-2) x (height-2)
// codes per frame, with row_end and frame_end flags. Throughput is one pixel per
// clock while req_stall and rsp_stall are low; a code passes the registered read
// of the two line-buffer RAMs and then the output register. After reset the
// line buffers are cleared to zero, one address per cycle, over all MAX_WIDTH
// addresses; req_stall is high during the clear; CSR writes are still taken.
// Width and height may only be changed while no request is in flight.
module lbp_3x3_stream_operator_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lbp_pkg::PIXEL_W-1:0]         req_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lbp_pkg::PIXEL_W-1:0]         rsp_lbp_code,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end,
   input  logic                                csr_we,
   input  logic [lbp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_WIDTH - 1);

   logic                        accept;
   logic [CW-1:0]               col;
   lbp_pkg::lbp_flags_type      flags;

   logic                        clr_ff, clr_in;
   logic [CW-1:0]               clr_addr_ff, clr_addr_in;

   logic                        s1_valid_ff, s1_valid_in;
   logic [lbp_pkg::PIXEL_W-1:0] s1_pixel_ff;
   logic [CW-1:0]               s1_col_ff;
   lbp_pkg::lbp_flags_type      s1_flags_ff;
   logic                        s1_advance;
   logic                        out_free;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lbp_pkg::PIXEL_W-1:0] rsp_code_ff;
   logic                        rsp_row_end_ff, rsp_frame_end_ff;

   logic                        ram_we;
   logic [CW-1:0]               ram_waddr;
   logic [lbp_pkg::PIXEL_W-1:0] upper_wdata, middle_wdata;
   logic [lbp_pkg::PIXEL_W-1:0] top, mid;
   logic [lbp_pkg::PIXEL_W-1:0] code;

   // ---- handshake ----
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && (!s1_flags_ff.emit || out_free);
   assign req_stall  = clr_ff || (s1_valid_ff && !s1_advance);
   assign accept     = req_valid && !req_stall;

   lbp_pos_counter #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .col       (col),
      .flags     (flags)
   );

   // ---- line-buffer clear after reset ----
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + CW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---- line buffers: read at accept, write back when the request leaves s1 ----
   always_comb begin
      if (clr_ff) begin
         ram_we       = 1'b1;
         ram_waddr    = clr_addr_ff;
         upper_wdata  = '0;
         middle_wdata = '0;
      end else begin
         ram_we       = s1_advance;
         ram_waddr    = s1_col_ff;
         upper_wdata  = mid;
         middle_wdata = s1_pixel_ff;
      end
   end

   lbp_ram #(
      .WIDTH (lbp_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (upper_wdata),
      .re    (accept),
      .raddr (col),
      .rdata (top)
   );

   lbp_ram #(
      .WIDTH (lbp_pkg::PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_middle_line (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (middle_wdata),
      .re    (accept),
      .raddr (col),
      .rdata (mid)
   );

   lbp_code_unit u_code (
      .clock (clock),
      .reset (reset),
      .shift (s1_advance),
      .top   (top),
      .mid   (mid),
      .bot   (s1_pixel_ff),
      .code  (code)
   );

   // ---- stage 1 register ----
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col;
         s1_flags_ff <= flags;
      end
   end

   // ---- output register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_flags_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_flags_ff.emit) begin
         rsp_code_ff      <= code;
         rsp_row_end_ff   <= s1_flags_ff.row_end;
         rsp_frame_end_ff <= s1_flags_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lbp_code  = rsp_code_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // ---- assertions ----
   a_no_req_during_clear : assert property (
      @(posedge clock) disable iff (reset) clr_ff |-> req_stall)
      else $error("request taken during line-buffer clear");

   a_no_overwrite : assert property (
      @(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_flags_ff.emit && rsp_valid_ff && rsp_stall) |-> !s1_advance)
      else $error("pending code overwritten");

   a_ram_no_collision : assert property (
      @(posedge clock) disable iff (reset)
      (accept && ram_we && !clr_ff) |-> (col != ram_waddr))
      else $error("line-buffer read and write at the same address");

   a_frame_end_on_row_end : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_end_ff) |-> rsp_row_end_ff)
      else $error("frame end without row end");

endmodule

### rtl/lbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/lbp_pos_counter.sv
// Frame geometry registers and the column/row position counters.
`timescale 1ns / 1ps

module lbp_pos_counter #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lbp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lbp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 advance,
   output logic [$clog2(MAX_WIDTH)-1:0]         col,
   output lbp_pkg::lbp_flags_type               flags
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = (CW + 1 > lbp_pkg::IMG_W_W) ? CW + 1 : lbp_pkg::IMG_W_W;
   localparam logic [LW-1:0] W_MAX = LW'(MAX_WIDTH);
   localparam logic [LW-1:0] W_MIN = LW'(3);

   logic [lbp_pkg::IMG_W_W-1:0] width_ff;
   logic [lbp_pkg::IMG_H_W-1:0] height_ff;
   logic [CW-1:0]               col_ff, col_in;
   logic [lbp_pkg::IMG_H_W-1:0] row_ff, row_in;

   logic [LW-1:0]               w_ext, w_eff;
   logic [lbp_pkg::IMG_H_W-1:0] h_eff;
   logic                        last_col, last_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lbp_pkg::IMAGE_WIDTH_RESET;
         height_ff <= lbp_pkg::IMAGE_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lbp_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[lbp_pkg::IMG_W_W-1:0];
            lbp_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[lbp_pkg::IMG_H_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_ext = LW'(width_ff);
      if (w_ext < W_MIN) begin
         w_eff = W_MIN;
      end else if (w_ext > W_MAX) begin
         w_eff = W_MAX;
      end else begin
         w_eff = w_ext;
      end
      h_eff = (height_ff < lbp_pkg::MIN_HEIGHT) ? lbp_pkg::MIN_HEIGHT : height_ff;

      // a counter at or past a shrunken limit counts as the last one
      last_col = (LW'(col_ff) + LW'(1)) >= w_eff;
      last_row = ({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff};

      flags.emit      = (row_ff >= 16'd2) && (col_ff >= CW'(2));
      flags.row_end   = last_col;
      flags.frame_end = last_col && last_row;

      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;

endmodule

### rtl/lbp_code_unit.sv
// Six-entry 3x3 window and the neighbour-versus-centre compare.
`timescale 1ns / 1ps

module lbp_code_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift,
   input  logic [lbp_pkg::PIXEL_W-1:0]  top,
   input  logic [lbp_pkg::PIXEL_W-1:0]  mid,
   input  logic [lbp_pkg::PIXEL_W-1:0]  bot,
   output logic [lbp_pkg::PIXEL_W-1:0]  code
);

   // entries 0..2: column c-2 top/mid/bottom, 3..5: column c-1
   logic [lbp_pkg::PIXEL_W-1:0] win_ff [6];
   logic [lbp_pkg::PIXEL_W-1:0] centre;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

   always_comb begin
      centre  = win_ff[4];
      code[7] = win_ff[0] >= centre;
      code[6] = win_ff[3] >= centre;
      code[5] = top       >= centre;
      code[4] = mid       >= centre;
      code[3] = bot       >= centre;
      code[2] = win_ff[5] >= centre;
      code[1] = win_ff[2] >= centre;
      code[0] = win_ff[1] >= centre;
   end

endmodule

### sim/tb_top.sv
// Testbench for the streaming 3x3 local binary pattern core.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_W        = 1024;
   localparam int WIDE_W       = 96;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 300;

   typedef logic [lbp_pkg::PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      logic [lbp_pkg::PIXEL_W-1:0] code;
      logic                        row_end;
      logic                        frame_end;
   } lbp_result_type;

   typedef enum int {PIX_UNIFORM, PIX_NEAR, PIX_RAILS} pix_style_type;
   typedef enum int {PH_WIDE_OOR, PH_SHORT_OOR, PH_TALL, PH_PARTIAL_CFG, PH_FRAMES} phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [lbp_pkg::PIXEL_W-1:0] req_pixel = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [lbp_pkg::PIXEL_W-1:0] rsp_lbp_code;
   logic rsp_row_end;
   logic rsp_frame_end;
   logic csr_we = 1'b0;
   logic [lbp_pkg::CSR_INDEX_W-1:0] csr_index = lbp_pkg::CSR_IMAGE_WIDTH;
   logic [lbp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the core: config, line buffers, window, position
   logic [lbp_pkg::IMG_W_W-1:0] img_width = lbp_pkg::IMAGE_WIDTH_RESET;
   logic [lbp_pkg::IMG_H_W-1:0] img_height = lbp_pkg::IMAGE_HEIGHT_RESET;
   logic [lbp_pkg::PIXEL_W-1:0] upper_row [0:MAX_W-1];
   logic [lbp_pkg::PIXEL_W-1:0] middle_row [0:MAX_W-1];
   logic [lbp_pkg::PIXEL_W-1:0] win [0:5];
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   logic [lbp_pkg::PIXEL_W-1:0] pending_pixels [$];
   lbp_result_type expected_codes [$];
   lbp_result_type want;

   logic [lbp_pkg::PIXEL_W-1:0] directed_px [0:26] = '{
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h00, 8'hFE, 8'hFF, 8'h01, 8'hFF, 8'hC8, 8'hFF, 8'h00, 8'h80,
      8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF};

   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   pix_style_type pix_style = PIX_UNIFORM;
   logic [lbp_pkg::PIXEL_W-1:0] pix_base = '0;
   int unsigned send_gap = 0;
   int unsigned rsp_gap = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_given = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned items_fed = 0;
   int unsigned errors = 0;

   always #2 clock = ~clock;

   lbp_3x3_stream_operator_core #(.MAX_WIDTH(MAX_W)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_lbp_code(rsp_lbp_code),
      .rsp_row_end(rsp_row_end),
      .rsp_frame_end(rsp_frame_end),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // advance the shadow by one accepted pixel, queue the code it yields
   function automatic void shift_in_pixel(input logic [lbp_pkg::PIXEL_W-1:0] bot);
      int unsigned w, h, c, r;
      logic [lbp_pkg::PIXEL_W-1:0] top, mid, centre;
      logic last_col, last_row;
      lbp_result_type res;
      w = 32'(img_width);
      if (w < 3) w = 3;
      if (w > MAX_W) w = MAX_W;
      h = 32'(img_height);
      if (h < 3) h = 3;
      c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      r = row_pos;
      top = upper_row[c];
      mid = middle_row[c];
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      if (r >= 2 && c >= 2) begin
         centre = win[4];
         res.code = {win[0] >= centre, win[3] >= centre, top >= centre, mid >= centre,
                     bot >= centre, win[5] >= centre, win[2] >= centre, win[1] >= centre};
         res.row_end = last_col;
         res.frame_end = last_col && last_row;
         expected_codes.push_back(res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = bot;
      upper_row[c] = mid;
      middle_row[c] = bot;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((r + 1) & 32'hFFFF);
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) shift_in_pixel(req_pixel);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
               req_pixel <= pending_pixels.pop_front();
               req_valid <= 1'b1;
               send_gap = send_burst ? 0 : $urandom_range(0, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               $display("%0t: unexpected result, expected none, %s %02h %s %0b %s %0b",
                        $time, "actual code", rsp_lbp_code, "row_end", rsp_row_end,
                        "frame_end", rsp_frame_end);
               errors++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_lbp_code !== want.code) begin
                  $display("%0t: lbp_code expected %02h actual %02h",
                           $time, want.code, rsp_lbp_code);
                  errors++;
               end
               if (rsp_row_end !== want.row_end) begin
                  $display("%0t: row_end expected %0b actual %0b",
                           $time, want.row_end, rsp_row_end);
                  errors++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $display("%0t: frame_end expected %0b actual %0b",
                           $time, want.frame_end, rsp_frame_end);
                  errors++;
               end
            end
            rsp_gap = recv_burst ? 0 : $urandom_range(0, 10);
         end
         if (hold_given != hold_asked) begin
            hold_given = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [lbp_pkg::CSR_INDEX_W-1:0] idx,
                            input int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[lbp_pkg::CSR_DATA_W-1:0];
      if (idx == lbp_pkg::CSR_IMAGE_WIDTH) img_width = value[lbp_pkg::IMG_W_W-1:0];
      else img_height = value[lbp_pkg::IMG_H_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // unused upper data bits get junk now and then
   task automatic set_width(input int unsigned w);
      write_csr(lbp_pkg::CSR_IMAGE_WIDTH,
                (w & 32'h7FF) | ($urandom_range(0, 31) << lbp_pkg::IMG_W_W));
   endtask

   task automatic feed(input int unsigned count);
      logic [lbp_pkg::PIXEL_W-1:0] px;
      @(negedge clock);
      for (int unsigned i = 0; i < count; i++) begin
         case (pix_style)
            PIX_UNIFORM: px = pixel_type'($urandom_range(0, 255));
            PIX_NEAR:    px = pixel_type'(pix_base + $urandom_range(0, 3));
            default:     px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         endcase
         pending_pixels.push_back(px);
      end
      items_fed += count;
   endtask

   // waits until every pixel is sent and every expected code is back, then lets the pipe settle
   task automatic drain();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_codes.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      int unsigned w, h, r, rand_start;
      phase_type kind;
      for (int i = 0; i < MAX_W; i++) begin
         upper_row[i] = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: ties everywhere, mixed extremes, alternating rails
      write_csr(lbp_pkg::CSR_IMAGE_WIDTH, 3);
      write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, 3);
      @(negedge clock);
      foreach (directed_px[i]) pending_pixels.push_back(directed_px[i]);
      drain();

      // wide frame, no idling, with a long receiver hold-off
      send_burst = 1'b1;
      recv_burst = 1'b1;
      set_width(WIDE_W);
      write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, 3);
      feed(WIDE_W * 3);
      hold_asked++;
      drain();

      rand_start = items_fed;
      while (items_fed - rand_start < RANDOM_ITEMS) begin
         send_burst = ($urandom_range(0, 3) == 0);
         recv_burst = ($urandom_range(0, 3) == 0);
         pix_style = pix_style_type'($urandom_range(0, 2));
         pix_base = pixel_type'($urandom_range(0, 252));
         r = $urandom_range(0, 9);
         kind = (r < 4) ? phase_type'(r) : PH_FRAMES;
         case (kind)
            PH_WIDE_OOR: begin
               if ($urandom_range(0, 1)) begin
                  h = $urandom_range(3, 5);
                  set_width($urandom_range(0, 2));
                  write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, h);
                  feed(3 * h);
               end else begin
                  set_width($urandom_range(MAX_W + 1, 2047));
                  feed($urandom_range(10, 60));
               end
            end
            PH_SHORT_OOR: begin
               w = $urandom_range(3, 12);
               set_width(w);
               write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, $urandom_range(0, 2));
               feed(w * 3 * $urandom_range(1, 2));
            end
            PH_TALL: begin
               w = $urandom_range(3, 8);
               set_width(w);
               write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, 65535);
               feed(w * $urandom_range(3, 6) + $urandom_range(0, w - 1));
            end
            PH_PARTIAL_CFG: begin
               // counters are kept across the change
               if ($urandom_range(0, 1)) set_width($urandom_range(3, 16));
               else write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, $urandom_range(3, 6));
               feed($urandom_range(5, 40));
            end
            default: begin
               w = $urandom_range(3, 16);
               h = $urandom_range(3, 6);
               set_width(w);
               write_csr(lbp_pkg::CSR_IMAGE_HEIGHT, h);
               feed(w * h * $urandom_range(1, 2));
            end
         endcase
         if ($urandom_range(0, 7) == 0) hold_asked++;
         drain();
      end

      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
